FILE: rtl/cbwu_pkg.sv
package cbwu_pkg;

    // default sizes
    localparam int CODEBOOK_DEPTH_DEF = 256;
    localparam int COUNT_WIDTH_DEF    = 24;

    // fixed field widths
    localparam int VALUE_W  = 8;
    localparam int SAMPLE_W = 9;
    localparam int WCOUNT_W = 24;
    localparam int HELD_W   = 4;
    localparam int BUF_W    = 15;

    // cells summed by one register of the read tree
    localparam int GROUP_SIZE = 16;

    // most weights cut from one packed byte
    localparam logic [3:0] MAX_PER_BYTE = 4'd8;

    // cycles spent waiting on the read tree
    localparam logic [1:0] RD_WAIT = 2'd2;

    // input word kinds
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_DATA = 1'b1;

    // configuration register indexes
    localparam logic CFG_SAMPLE_COUNT = 1'b0;
    localparam logic CFG_WEIGHT_COUNT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXTRACT,
        ST_LOOKUP
    } state_t;

    // load command broadcast along the cell row
    typedef struct packed {
        logic               load;
        logic [VALUE_W-1:0] value;
    } cb_ctrl_t;

    // what a cell hands to its right-hand neighbour
    typedef struct packed {
        logic               greater;
        logic [VALUE_W-1:0] entry;
    } cb_link_t;

    // index width for a codebook of n entries, at least one bit
    function automatic logic [HELD_W-1:0] index_bits(input logic [SAMPLE_W-1:0] n);
        logic [HELD_W-1:0] w;
        w = HELD_W'(8);
        for (int k = 7; k >= 1; k--) begin
            if ((SAMPLE_W'(1) << k) >= n) begin
                w = HELD_W'(k);
            end
        end
        return w;
    endfunction

endpackage

FILE: rtl/cbwu_cell.sv
module cbwu_cell #(
    parameter int POS   = 0,
    parameter int IDX_W = 8
) (
    input  logic                                clk,
    input  cbwu_pkg::cb_ctrl_t                  ctrl,
    input  logic [cbwu_pkg::SAMPLE_W-1:0]       loaded,
    input  logic [IDX_W-1:0]                    idx,
    input  cbwu_pkg::cb_link_t                  prev,
    output cbwu_pkg::cb_link_t                  link,
    output logic [cbwu_pkg::VALUE_W-1:0]        sel_data
);
    import cbwu_pkg::*;

    logic [VALUE_W-1:0] entry_reg;
    logic [VALUE_W-1:0] entry_next;
    logic [VALUE_W-1:0] sel_reg;
    logic               occupied;
    logic               greater;

    // an empty cell counts as larger than any byte
    assign occupied = SAMPLE_W'(POS) < loaded;
    assign greater  = !occupied || ($signed(entry_reg) > $signed(ctrl.value));

    assign link.greater = greater;
    assign link.entry   = entry_reg;
    assign sel_data     = sel_reg;

    // insertion: take the left neighbour's entry or the new byte
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.load && greater) begin
            if (prev.greater) begin
                entry_next = prev.entry;
            end
            else begin
                entry_next = ctrl.value;
            end
        end
    end

    // entry and read-out registers
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        sel_reg   <= (idx == IDX_W'(POS)) ? entry_reg : '0;
    end

endmodule

FILE: rtl/cbwu_codebook.sv
module cbwu_codebook #(
    parameter int CODEBOOK_DEPTH = cbwu_pkg::CODEBOOK_DEPTH_DEF,
    parameter int IDX_W          = $clog2(CODEBOOK_DEPTH)
) (
    input  logic                                clk,
    input  cbwu_pkg::cb_ctrl_t                  ctrl,
    input  logic [cbwu_pkg::SAMPLE_W-1:0]       loaded,
    input  logic [IDX_W-1:0]                    idx,
    output logic [cbwu_pkg::VALUE_W-1:0]        rd_data
);
    import cbwu_pkg::*;

    localparam int NGROUP = (CODEBOOK_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

    cb_link_t           links [CODEBOOK_DEPTH];
    logic [VALUE_W-1:0] sel   [CODEBOOK_DEPTH];
    logic [VALUE_W-1:0] group_reg [NGROUP];

    // sorted row of cells, smallest entry on the left
    for (genvar i = 0; i < CODEBOOK_DEPTH; i++) begin : g_cell
        cb_link_t prev;
        if (i == 0) begin : g_first
            assign prev = '0;
        end
        else begin : g_rest
            assign prev = links[i-1];
        end
        cbwu_cell #(
            .POS   (i),
            .IDX_W (IDX_W)
        ) u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .loaded   (loaded),
            .idx      (idx),
            .prev     (prev),
            .link     (links[i]),
            .sel_data (sel[i])
        );
    end

    // first level of the read tree, one register per group of cells
    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NGROUP; g++) begin
            logic [VALUE_W-1:0] acc;
            acc = '0;
            for (int k = 0; k < GROUP_SIZE; k++) begin
                if (g * GROUP_SIZE + k < CODEBOOK_DEPTH) begin
                    acc = acc | sel[g * GROUP_SIZE + k];
                end
            end
            group_reg[g] <= acc;
        end
    end

    // final level of the read tree
    always_comb
    begin
        rd_data = '0;
        for (int g = 0; g < NGROUP; g++) begin
            rd_data = rd_data | group_reg[g];
        end
    end

endmodule

FILE: rtl/codebook_weight_unpacker_core.sv
// Codebook weight unpacker. Words with tuser low load signed codebook bytes into
// a row of cells kept in ascending order (one cell per entry, one load word per
// cycle while idle); loads past the configured sample count are dropped. Words
// with tuser high carry packed bytes that are cut MSB first into indices of
// ceil(log2(sample_count)) bits (at least one bit), an index may span two bytes.
// Each index gives the sorted entry as a signed weight on m_tdata; an index at
// or above the sample count gives weight 0 with tuser high. After weight_count
// weights the last one carries tlast and later data words are swallowed until
// reset. A load word or a swallowed data word leaves the block idle. While a
// data word is worked on s_tready stays low: each index is cut in the extract
// state, then the lookup state waits on the registered read tree over the cell
// row and emits once the output register is free, so m_tready back-pressure
// stalls it. Configure only while idle.
module codebook_weight_unpacker_core #(
    parameter int CODEBOOK_DEPTH = cbwu_pkg::CODEBOOK_DEPTH_DEF,
    parameter int COUNT_WIDTH    = cbwu_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input words
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [cbwu_pkg::VALUE_W-1:0]        s_tdata,   // [7:0] value
    input  logic                                s_tuser,   // [0] mode
    // output words
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic signed [cbwu_pkg::VALUE_W-1:0] m_tdata,   // [7:0] weight
    output logic                                m_tuser,   // [0] index_error
    output logic                                m_tlast,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_index,
    input  logic [cbwu_pkg::WCOUNT_W-1:0]       cfg_data
);
    import cbwu_pkg::*;

    localparam int IDX_W = $clog2(CODEBOOK_DEPTH);

    state_t                 state_reg, state_next;
    logic [SAMPLE_W-1:0]    sample_count_reg;
    logic [WCOUNT_W-1:0]    weight_count_reg;
    logic [SAMPLE_W-1:0]    loaded_reg, loaded_next;
    logic [BUF_W-1:0]       buf_reg, buf_next;
    logic [HELD_W-1:0]      held_reg, held_next;
    logic [COUNT_WIDTH-1:0] emitted_reg, emitted_next;
    logic                   finished_reg, finished_next;
    logic [3:0]             produced_reg, produced_next;
    logic [1:0]             wait_reg, wait_next;
    logic [VALUE_W-1:0]     idx_reg, idx_next;
    logic                   err_reg, err_next;
    logic                   zero_reg, zero_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [VALUE_W-1:0]     m_tdata_reg, m_tdata_next;
    logic                   m_tuser_reg, m_tuser_next;
    logic                   m_tlast_reg, m_tlast_next;

    logic [SAMPLE_W-1:0]    n_raw;
    logic [SAMPLE_W-1:0]    n_eff;
    logic [HELD_W-1:0]      w;
    logic [HELD_W-1:0]      held_after;
    logic [BUF_W-1:0]       ext;
    logic [VALUE_W-1:0]     ext_mask;
    logic [VALUE_W-1:0]     ext_idx;
    logic [BUF_W-1:0]       buf_keep;
    logic [COUNT_WIDTH-1:0] emitted_inc;
    logic                   is_last;
    logic                   out_free;
    cb_ctrl_t               cb_ctrl;
    logic [VALUE_W-1:0]     rd_data;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = $signed(m_tdata_reg);
    assign m_tuser   = m_tuser_reg;
    assign m_tlast   = m_tlast_reg;

    // effective codebook size and index width
    assign n_raw = (sample_count_reg == '0) ? SAMPLE_W'(256) : sample_count_reg;
    assign n_eff = (n_raw > SAMPLE_W'(CODEBOOK_DEPTH)) ? SAMPLE_W'(CODEBOOK_DEPTH) : n_raw;
    assign w     = index_bits(n_eff);

    // cut the next index from the top of the held bits
    assign held_after = held_reg - w;
    assign ext        = buf_reg >> held_after;
    assign ext_mask   = VALUE_W'((SAMPLE_W'(1) << w) - SAMPLE_W'(1));
    assign ext_idx    = ext[VALUE_W-1:0] & ext_mask;
    assign buf_keep   = buf_reg & BUF_W'((16'(1) << held_after) - 16'(1));

    assign emitted_inc = emitted_reg + COUNT_WIDTH'(1);
    assign is_last     = (emitted_inc == COUNT_WIDTH'(weight_count_reg));
    assign out_free    = !m_tvalid_reg || m_tready;

    cbwu_codebook #(
        .CODEBOOK_DEPTH (CODEBOOK_DEPTH),
        .IDX_W          (IDX_W)
    ) u_codebook (
        .clk     (clk),
        .ctrl    (cb_ctrl),
        .loaded  (loaded_reg),
        .idx     (IDX_W'(idx_reg)),
        .rd_data (rd_data)
    );

    // next state and outputs
    always_comb
    begin
        state_next    = state_reg;
        loaded_next   = loaded_reg;
        buf_next      = buf_reg;
        held_next     = held_reg;
        emitted_next  = emitted_reg;
        finished_next = finished_reg;
        produced_next = produced_reg;
        wait_next     = wait_reg;
        idx_next      = idx_reg;
        err_next      = err_reg;
        zero_next     = zero_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        cb_ctrl.load  = 1'b0;
        cb_ctrl.value = s_tdata;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid) begin
                    if (s_tuser == MODE_LOAD) begin
                        if (loaded_reg < n_eff) begin
                            cb_ctrl.load = 1'b1;
                            loaded_next  = loaded_reg + SAMPLE_W'(1);
                        end
                    end
                    else if (!finished_reg) begin
                        buf_next      = {buf_reg[BUF_W-VALUE_W-1:0], s_tdata};
                        held_next     = held_reg + HELD_W'(8);
                        produced_next = '0;
                        state_next    = ST_EXTRACT;
                    end
                end
            end
            ST_EXTRACT:
            begin
                if (held_reg >= w && produced_reg < MAX_PER_BYTE) begin
                    idx_next   = ext_idx;
                    held_next  = held_after;
                    buf_next   = buf_keep;
                    err_next   = {1'b0, ext_idx} >= n_eff;
                    zero_next  = {1'b0, ext_idx} >= loaded_reg;
                    wait_next  = '0;
                    state_next = ST_LOOKUP;
                end
                else begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOOKUP:
            begin
                if (wait_reg != RD_WAIT) begin
                    wait_next = wait_reg + 2'd1;
                end
                else if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = (err_reg || zero_reg) ? '0 : rd_data;
                    m_tuser_next  = err_reg;
                    m_tlast_next  = is_last;
                    emitted_next  = emitted_inc;
                    produced_next = produced_reg + 4'd1;
                    if (is_last) begin
                        finished_next = 1'b1;
                        buf_next      = '0;
                        held_next     = '0;
                        state_next    = ST_IDLE;
                    end
                    else begin
                        state_next = ST_EXTRACT;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg        <= ST_IDLE;
            sample_count_reg <= SAMPLE_W'(256);
            weight_count_reg <= WCOUNT_W'(1);
            loaded_reg       <= '0;
            buf_reg          <= '0;
            held_reg         <= '0;
            emitted_reg      <= '0;
            finished_reg     <= 1'b0;
            produced_reg     <= '0;
            wait_reg         <= '0;
            m_tvalid_reg     <= 1'b0;
        end
        else begin
            state_reg    <= state_next;
            loaded_reg   <= loaded_next;
            buf_reg      <= buf_next;
            held_reg     <= held_next;
            emitted_reg  <= emitted_next;
            finished_reg <= finished_next;
            produced_reg <= produced_next;
            wait_reg     <= wait_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid) begin
                if (cfg_index == CFG_SAMPLE_COUNT) begin
                    sample_count_reg <= cfg_data[SAMPLE_W-1:0];
                end
                else begin
                    weight_count_reg <= cfg_data;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        err_reg     <= err_next;
        zero_reg    <= zero_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    // index must hold while the read tree settles
    a_idx_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOKUP && $past(state_reg) == ST_LOOKUP) |-> $stable(idx_reg))
        else $error("index changed during lookup");

    // an accepted load with room left grows the codebook by one
    a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == MODE_LOAD && loaded_reg < n_eff)
        |=> loaded_reg == $past(loaded_reg) + SAMPLE_W'(1))
        else $error("load not counted");

    // a word flagged last only ever comes with decoding finished
    a_last_finished: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && m_tlast_reg) |-> finished_reg)
        else $error("last word without finish");

    // no fresh word after decoding has finished
    a_no_word_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> !$past(finished_reg))
        else $error("word emitted after finish");

endmodule
